FILE: src/nro_pkg.sv
// Shared types, function codes and defaults for the NKRO report orderer.
package nro_pkg;

  localparam int KEY_BYTE_COUNT_DEF = 28;
  localparam int LAST_KEY_CODE_DEF  = 221;

  localparam logic [2:0] FN_PRESS   = 3'd0;
  localparam logic [2:0] FN_RELEASE = 3'd1;
  localparam logic [2:0] FN_RALL    = 3'd2;
  localparam logic [2:0] FN_QUERY   = 3'd3;
  localparam logic [2:0] FN_SEND    = 3'd4;

  localparam logic [7:0] FIRST_MOD = 8'd224;
  localparam logic [7:0] LAST_MOD  = 8'd231;

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_WORD = 1'b1;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] keycode;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic        accepted;
    logic        key_now;
    logic        key_before;
    logic        any_mod_now;
    logic        any_mod_before;
    logic [63:0] report_word;
    logic [1:0]  word_index;
    logic        report_end;
    logic        run_end;
  } result_t;

endpackage

FILE: src/nkro_report_orderer.sv
// NKRO keyboard report orderer: current and last-sent reports held in one key-byte memory.
// A send scans the key memory, decides, then emits each report as 64-bit words built by byte
// walking, WORDS = (KEY_BYTE_COUNT + 8) / 8 words per report; a full send emits three
// reports. The key memory has a single read port, read one byte per cycle. Result
// transactions appear on result for one cycle with result_strobe high and cannot be held
// off. After reset the block clears the key memory with busy high.
module nkro_report_orderer #(
  parameter int KEY_BYTE_COUNT = nro_pkg::KEY_BYTE_COUNT_DEF,
  parameter int LAST_KEY_CODE  = nro_pkg::LAST_KEY_CODE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  nro_pkg::item_t    item,
  output logic              busy,
  output nro_pkg::result_t  result,
  output logic              result_strobe
);

  localparam int WORDS = (KEY_BYTE_COUNT + 8) / 8;
  localparam int NB    = 8 * WORDS;
  localparam int AW    = (KEY_BYTE_COUNT > 1) ? $clog2(KEY_BYTE_COUNT) : 1;
  localparam int CW    = $clog2(NB + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_OP     = 3'd2;
  localparam logic [2:0] ST_RALL   = 3'd3;
  localparam logic [2:0] ST_SCAN   = 3'd4;
  localparam logic [2:0] ST_DECIDE = 3'd5;
  localparam logic [2:0] ST_REP    = 3'd6;

  localparam logic [1:0] PH_A = 2'd0;  // released keys cleared
  localparam logic [1:0] PH_B = 2'd1;  // new modifiers
  localparam logic [1:0] PH_C = 2'd2;  // keys copied

  function automatic logic is_key(logic [7:0] k);
    return (k <= 8'(LAST_KEY_CODE)) && ({3'd0, k[7:3]} < 8'(KEY_BYTE_COUNT));
  endfunction

  function automatic logic is_mod(logic [7:0] k);
    return (k >= nro_pkg::FIRST_MOD) && (k <= nro_pkg::LAST_MOD);
  endfunction

  // entry: [15:8] last-sent key byte, [7:0] current key byte
  logic [15:0] mem [KEY_BYTE_COUNT];
  logic [15:0] rdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          we;

  logic [2:0]  state;
  logic [1:0]  phase;
  logic [CW-1:0] cnt;
  logic [CW-1:0] d_pos;
  logic        d_vld;
  logic [2:0]  func;
  logic [7:0]  keycode;
  logic        rel_any;
  logic        press_any;
  logic [63:0] acc;
  logic [7:0]  cap_sent;
  logic [7:0]  cur_mods;
  logic [7:0]  sent_mods;

  logic          lk_key;
  logic          lk_mod;
  logic [AW-1:0] lk_idx;
  logic [7:0]    kbit;
  logic [AW-1:0] in_idx;
  logic [CW-1:0] sweep_limit;
  logic          issue;
  logic          last;
  logic [7:0]    op_cur;
  logic [7:0]    op_mods;
  nro_pkg::result_t ack;
  nro_pkg::result_t rall_ack;
  nro_pkg::result_t word_res;
  logic [7:0]    rep_byte;
  logic          rep_key;
  logic [7:0]    rall_sent;

  assign busy = (state != ST_IDLE);

  assign lk_key = is_key(keycode);
  assign lk_mod = is_mod(keycode);
  assign lk_idx = lk_key ? AW'(keycode[7:3]) : '0;
  assign kbit   = 8'd1 << keycode[2:0];
  assign in_idx = is_key(item.keycode) ? AW'(item.keycode[7:3]) : '0;

  assign sweep_limit = (state == ST_REP) ? CW'(NB) : CW'(KEY_BYTE_COUNT);
  assign issue       = (cnt < sweep_limit);
  assign last        = d_vld && (d_pos == sweep_limit - CW'(1));

  // position 0 is the modifier byte, then key bytes, then zero padding
  assign rep_key = (d_pos >= CW'(1)) && (d_pos <= CW'(KEY_BYTE_COUNT));

  always_comb begin
    rep_byte = 8'd0;
    if (d_pos == '0) begin
      rep_byte = sent_mods;
    end else if (rep_key) begin
      case (phase)
        PH_A:    rep_byte = rdata[15:8] & rdata[7:0];
        PH_B:    rep_byte = rdata[15:8];
        PH_C:    rep_byte = rdata[7:0];
        default: rep_byte = rdata[15:8];
      endcase
    end
  end

  // single-key edit
  always_comb begin
    op_cur  = rdata[7:0];
    op_mods = cur_mods;
    case (func)
      nro_pkg::FN_PRESS: begin
        if (lk_key) op_cur = rdata[7:0] | kbit;
        else if (lk_mod) op_mods = cur_mods | kbit;
      end
      nro_pkg::FN_RELEASE: begin
        if (lk_key) op_cur = rdata[7:0] & ~kbit;
        else if (lk_mod) op_mods = cur_mods & ~kbit;
      end
      default: begin
        op_cur  = rdata[7:0];
        op_mods = cur_mods;
      end
    endcase
  end

  always_comb begin
    ack = '0;
    ack.kind = nro_pkg::KIND_ACK;
    ack.accepted = (func inside {nro_pkg::FN_PRESS, nro_pkg::FN_RELEASE, nro_pkg::FN_QUERY})
                   && (lk_key || lk_mod);
    if (lk_key) begin
      ack.key_now    = |(op_cur & kbit);
      ack.key_before = |(rdata[15:8] & kbit);
    end else if (lk_mod) begin
      ack.key_now    = |(op_mods & kbit);
      ack.key_before = |(sent_mods & kbit);
    end
    ack.any_mod_now    = |op_mods;
    ack.any_mod_before = |sent_mods;
    ack.run_end        = 1'b1;
  end

  assign rall_sent = (d_pos == CW'(lk_idx)) ? rdata[15:8] : cap_sent;

  always_comb begin
    rall_ack = '0;
    rall_ack.kind     = nro_pkg::KIND_ACK;
    rall_ack.accepted = 1'b1;
    if (lk_key) rall_ack.key_before = |(rall_sent & kbit);
    else if (lk_mod) rall_ack.key_before = |(sent_mods & kbit);
    rall_ack.any_mod_before = |sent_mods;
    rall_ack.run_end        = 1'b1;
  end

  always_comb begin
    word_res = '0;
    word_res.kind        = nro_pkg::KIND_WORD;
    word_res.report_word = {rep_byte, acc[63:8]};
    word_res.word_index  = 2'(d_pos >> 3);
    word_res.report_end  = (d_pos == CW'(NB - 1));
    word_res.run_end     = word_res.report_end &&
                           ((phase == PH_C) || ((phase == PH_B) && !press_any));
  end

  // memory port control
  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    case (state)
      ST_IDLE: raddr = in_idx;
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = AW'(cnt);
      end
      ST_OP: begin
        we    = lk_key && (func inside {nro_pkg::FN_PRESS, nro_pkg::FN_RELEASE});
        waddr = lk_idx;
        wdata = {rdata[15:8], op_cur};
      end
      ST_RALL: begin
        raddr = issue ? AW'(cnt) : '0;
        we    = d_vld;
        waddr = AW'(d_pos);
        wdata = {rdata[15:8], 8'd0};
      end
      ST_SCAN: raddr = issue ? AW'(cnt) : '0;
      ST_REP: begin
        if ((cnt >= CW'(1)) && (cnt <= CW'(KEY_BYTE_COUNT))) raddr = AW'(cnt - CW'(1));
        we    = d_vld && rep_key && (phase != PH_B);
        waddr = AW'(d_pos - CW'(1));
        wdata = {rep_byte, rdata[7:0]};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    result_strobe <= 1'b0;
    if (rst) begin
      state     <= ST_CLEAR;
      phase     <= PH_A;
      cnt       <= '0;
      d_vld     <= 1'b0;
      cur_mods  <= 8'd0;
      sent_mods <= 8'd0;
      rel_any   <= 1'b0;
      press_any <= 1'b0;
    end else begin
      if (state == ST_RALL || state == ST_SCAN || state == ST_REP) begin
        if (issue) cnt <= cnt + CW'(1);
        d_vld <= issue;
        d_pos <= cnt;
        if (last) cnt <= '0;
      end
      case (state)
        ST_CLEAR: begin
          if (cnt == CW'(KEY_BYTE_COUNT - 1)) begin
            state <= ST_IDLE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_IDLE: begin
          if (start) begin
            func      <= item.func;
            keycode   <= item.keycode;
            cnt       <= '0;
            d_vld     <= 1'b0;
            rel_any   <= 1'b0;
            press_any <= 1'b0;
            case (item.func)
              nro_pkg::FN_RALL: state <= ST_RALL;
              nro_pkg::FN_SEND: state <= ST_SCAN;
              default:          state <= ST_OP;
            endcase
          end
        end
        ST_OP: begin
          cur_mods      <= op_mods;
          result        <= ack;
          result_strobe <= 1'b1;
          state         <= ST_IDLE;
        end
        ST_RALL: begin
          if (d_vld && (d_pos == CW'(lk_idx))) cap_sent <= rdata[15:8];
          if (last) begin
            cur_mods      <= 8'd0;
            result        <= rall_ack;
            result_strobe <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (d_vld) begin
            rel_any   <= rel_any | (|(rdata[15:8] & ~rdata[7:0]));
            press_any <= press_any | (|(rdata[7:0] & ~rdata[15:8]));
          end
          if (last) state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (cur_mods != sent_mods) begin
            state <= ST_REP;
            if (rel_any) begin
              phase <= PH_A;
            end else begin
              phase     <= PH_B;
              sent_mods <= cur_mods;
            end
          end else if (rel_any || press_any) begin
            state <= ST_REP;
            phase <= PH_C;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_REP: begin
          if (d_vld) begin
            acc <= {rep_byte, acc[63:8]};
            if (d_pos[2:0] == 3'b111) begin
              result        <= word_res;
              result_strobe <= 1'b1;
            end
          end
          if (last) begin
            case (phase)
              PH_A: begin
                phase     <= PH_B;
                sent_mods <= cur_mods;
              end
              PH_B: begin
                if (press_any) phase <= PH_C;
                else state <= ST_IDLE;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: src/nro_checker.sv
// Port-level checker for the NKRO report orderer, bound to the top level.
module nro_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input nro_pkg::item_t   item,
  input logic             busy,
  input nro_pkg::result_t result,
  input logic             result_strobe
);

  a_ack_ends_run: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && (result.kind == nro_pkg::KIND_ACK)) |-> result.run_end)
    else $error("acknowledge without run_end");

  a_ack_no_word: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && (result.kind == nro_pkg::KIND_ACK)) |->
      ((result.report_word == 64'd0) && (result.word_index == 2'd0) && !result.report_end))
    else $error("acknowledge carries report data");

  a_word_no_flags: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && (result.kind == nro_pkg::KIND_WORD)) |->
      (!result.accepted && !result.key_now && !result.key_before &&
       !result.any_mod_now && !result.any_mod_before))
    else $error("report word carries query flags");

  a_run_end_on_report_end: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && (result.kind == nro_pkg::KIND_WORD) && !result.report_end) |->
      !result.run_end)
    else $error("run ended inside a report");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transaction accepted without going busy");

endmodule

bind nkro_report_orderer nro_checker u_nro_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .item          (item),
  .busy          (busy),
  .result        (result),
  .result_strobe (result_strobe)
);
